FILE: rtl/arpc_pkg.sv
package arpc_pkg;

	localparam int IP_W       = 32;
	localparam int MAC_W      = 48;
	localparam int OUT_IDX_W  = 4;
	localparam int MAC_HI_LSB = 40;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	typedef struct packed {
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
	} entry_t;

	typedef struct packed {
		logic                 found;
		logic [OUT_IDX_W-1:0] entry_index;
		logic [MAC_W-1:0]     entry_mac;
		logic                 stored;
	} result_t;

endpackage

FILE: rtl/arpc_mem.sv
module arpc_mem #(
	parameter int CACHE_ENTRIES = 16,
	parameter int IDX_W         = $clog2(CACHE_ENTRIES)
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_addr,
	input  arpc_pkg::entry_t    wr_data,
	input  logic                rd_en,
	input  logic [IDX_W-1:0]    rd_addr,
	output arpc_pkg::entry_t    rd_data
);
	import arpc_pkg::*;

	logic [IP_W-1:0]  ip_mem  [CACHE_ENTRIES];
	logic [MAC_W-1:0] mac_mem [CACHE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ip_mem[wr_addr]  <= wr_data.ip;
			mac_mem[wr_addr] <= wr_data.mac;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data.ip  <= ip_mem[rd_addr];
			rd_data.mac <= mac_mem[rd_addr];
		end
	end

endmodule

FILE: rtl/arpc_ctrl.sv
module arpc_ctrl #(
	parameter int CACHE_ENTRIES = 16,
	parameter int IDX_W         = $clog2(CACHE_ENTRIES),
	parameter int CNT_W         = $clog2(CACHE_ENTRIES + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       op,
	input  logic [arpc_pkg::IP_W-1:0]  ip_addr,
	input  logic [arpc_pkg::MAC_W-1:0] mac_addr,
	output logic                       mem_wr_en,
	output logic [IDX_W-1:0]           mem_wr_addr,
	output arpc_pkg::entry_t           mem_wr_data,
	output logic                       mem_rd_en,
	output logic [IDX_W-1:0]           mem_rd_addr,
	input  arpc_pkg::entry_t           mem_rd_data,
	output arpc_pkg::result_t          result,
	output logic                       done
);
	import arpc_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CACHE_ENTRIES);

	logic              state_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  issue_idx_q;
	logic              cmp_valid_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;
	logic              op_q;
	logic [IP_W-1:0]   ip_q;
	logic [MAC_W-1:0]  mac_q;
	logic              done_q;
	result_t           result_q;

	logic              accept;
	logic              hit;
	logic              last;
	logic              finish;
	logic              insert_ok;
	logic [IDX_W+OUT_IDX_W-1:0] hit_idx_ext;
	logic [CNT_W+OUT_IDX_W-1:0] new_idx_ext;

	assign busy   = (state_q == ST_SCAN);
	assign accept = start && !busy;
	assign hit    = busy && cmp_valid_s1 && (mem_rd_data.ip == ip_q);
	assign last   = (issue_idx_q == fill_q);
	assign finish = busy && (hit || last);

	assign insert_ok = (op_q == OP_INSERT) && (fill_q != FULL_COUNT)
		&& (mac_q[MAC_W-1:MAC_HI_LSB] != '0);

	assign hit_idx_ext = {{OUT_IDX_W{1'b0}}, cmp_idx_s1};
	assign new_idx_ext = {{OUT_IDX_W{1'b0}}, fill_q};

	assign mem_rd_en   = busy && !hit && !last;
	assign mem_rd_addr = issue_idx_q[IDX_W-1:0];

	assign mem_wr_en        = busy && !hit && last && insert_ok;
	assign mem_wr_addr      = fill_q[IDX_W-1:0];
	assign mem_wr_data.ip   = ip_q;
	assign mem_wr_data.mac  = mac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			cmp_valid_s1 <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= finish;
			unique case (state_q)
				ST_IDLE: begin
					cmp_valid_s1 <= 1'b0;
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_valid_s1 <= mem_rd_en;
					if (finish) begin
						state_q <= ST_IDLE;
					end
					if (mem_wr_en) begin
						fill_q <= fill_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= op;
			ip_q        <= ip_addr;
			mac_q       <= mac_addr;
			issue_idx_q <= '0;
		end else if (mem_rd_en) begin
			issue_idx_q <= issue_idx_q + 1'b1;
			cmp_idx_s1  <= issue_idx_q[IDX_W-1:0];
		end
		if (finish) begin
			if (hit) begin
				result_q.found       <= 1'b1;
				result_q.entry_index <= hit_idx_ext[OUT_IDX_W-1:0];
				result_q.entry_mac   <= mem_rd_data.mac;
				result_q.stored      <= 1'b0;
			end else if (insert_ok) begin
				result_q.found       <= 1'b0;
				result_q.entry_index <= new_idx_ext[OUT_IDX_W-1:0];
				result_q.entry_mac   <= '0;
				result_q.stored      <= 1'b1;
			end else begin
				result_q.found       <= 1'b0;
				result_q.entry_index <= '0;
				result_q.entry_mac   <= '0;
				result_q.stored      <= 1'b0;
			end
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

FILE: rtl/arp_address_cache_top.sv
// Fill-only IPv4 to Ethernet address cache. Pulse start while busy is low to
// issue a transaction: op 0 looks up ip_addr, op 1 inserts the ip_addr and
// mac_addr pair at the next free entry unless the address is already held,
// the cache is full or the first MAC byte is zero. Each transaction yields one
// result on found, entry_index, entry_mac and stored, shown for exactly one
// cycle while done is high; the receiver cannot stall, so capture it then.
// The entries are scanned in order through one synchronous memory read port,
// one entry per cycle; the scan ends at the first hit or once every filled
// entry has been compared, and an insert is written as that scan misses.
// busy falls in the cycle done is shown, so the next start may be taken at
// that edge. Entries are never evicted; reset empties the cache at once, no
// clearing pass is needed.
module arp_address_cache_top #(
	parameter int CACHE_ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       op,
	input  logic [arpc_pkg::IP_W-1:0]  ip_addr,
	input  logic [arpc_pkg::MAC_W-1:0] mac_addr,
	output logic                       done,
	output logic                       found,
	output logic [arpc_pkg::OUT_IDX_W-1:0] entry_index,
	output logic [arpc_pkg::MAC_W-1:0] entry_mac,
	output logic                       stored
);
	import arpc_pkg::*;

	localparam int IDX_W = $clog2(CACHE_ENTRIES);

	logic             mem_wr_en;
	logic [IDX_W-1:0] mem_wr_addr;
	entry_t           mem_wr_data;
	logic             mem_rd_en;
	logic [IDX_W-1:0] mem_rd_addr;
	entry_t           mem_rd_data;
	result_t          result;

	arpc_ctrl #(
		.CACHE_ENTRIES (CACHE_ENTRIES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.ip_addr     (ip_addr),
		.mac_addr    (mac_addr),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.result      (result),
		.done        (done)
	);

	arpc_mem #(
		.CACHE_ENTRIES (CACHE_ENTRIES)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	assign found       = result.found;
	assign entry_index = result.entry_index;
	assign entry_mac   = result.entry_mac;
	assign stored      = result.stored;

endmodule
